[hdl/rgpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray ground point classifier package
// Payload types, register map and reset values shared by the classifier.
// ----------------------------------------------------------------------------
package rgpc_pkg;

    localparam int RADIUS_W = 17;
    localparam int HEIGHT_W = 16;
    localparam int INDEX_W  = 16;
    localparam int TAN_W    = 16;
    localparam int SENSOR_W = 13;
    localparam int MINH_W   = 12;
    localparam int CONC_W   = 12;
    localparam int RECL_W   = 16;

    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REGSEL_W = 3;

    localparam logic [REGSEL_W-1:0] REG_SENSOR_HEIGHT = 3'd0;
    localparam logic [REGSEL_W-1:0] REG_TAN_LOCAL     = 3'd1;
    localparam logic [REGSEL_W-1:0] REG_TAN_GENERAL   = 3'd2;
    localparam logic [REGSEL_W-1:0] REG_MIN_HEIGHT    = 3'd3;
    localparam logic [REGSEL_W-1:0] REG_CONC_STEP     = 3'd4;
    localparam logic [REGSEL_W-1:0] REG_RECLASS_DIST  = 3'd5;

    localparam logic [SENSOR_W-1:0] SENSOR_HEIGHT_RST = 13'd1750;
    localparam logic [TAN_W-1:0]    TAN_LOCAL_RST     = 16'd9210;
    localparam logic [TAN_W-1:0]    TAN_GENERAL_RST   = 16'd5734;
    localparam logic [MINH_W-1:0]   MIN_HEIGHT_RST    = 12'd50;
    localparam logic [CONC_W-1:0]   CONC_STEP_RST     = 12'd10;
    localparam logic [RECL_W-1:0]   RECLASS_DIST_RST  = 16'd200;

    typedef struct packed {
        logic [RADIUS_W-1:0]        radius_mm;
        logic signed [HEIGHT_W-1:0] height_mm;
        logic                       ray_start;
        logic [INDEX_W-1:0]         point_index;
    } in_item_t;

    typedef struct packed {
        logic               is_ground;
        logic [INDEX_W-1:0] result_index;
    } out_item_t;

endpackage

[hdl/ray_ground_point_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray ground point classifier
// Classifies radius-sorted lidar points of each ray as ground or not ground.
// ----------------------------------------------------------------------------
// Each accepted point is held in an input register, classified and written to
// a result register, from which its result is offered, and a new point can be
// taken in every cycle while the output is not stalled. The rate is set by
// the per-ray state (previous radius, height and ground flag), which is read
// and updated in the classify step together with two 16x17 bit slope
// multiplications. Thresholds are truncated Q0.16 products in millimeters;
// the user must write registers through the APB port only while no point is
// in flight; the block itself does not enforce this.
module ray_ground_point_classifier
    import rgpc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,

    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [SENSOR_W-1:0] sensor_height_reg;
    logic [TAN_W-1:0]    tan_local_reg;
    logic [TAN_W-1:0]    tan_general_reg;
    logic [MINH_W-1:0]   min_height_reg;
    logic [CONC_W-1:0]   conc_step_reg;
    logic [RECL_W-1:0]   reclass_dist_reg;

    logic                in_valid_reg;
    in_item_t            in_data_reg;
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic [RADIUS_W-1:0]        last_radius_reg;
    logic signed [HEIGHT_W-1:0] last_height_reg;
    logic                       last_ground_reg;

    logic                      advance;
    logic                      classify;
    logic [REGSEL_W-1:0]       reg_sel;
    logic                      cfg_write;

    logic signed [13:0]         ground_level;
    logic [RADIUS_W-1:0]        base_radius;
    logic signed [HEIGHT_W-1:0] base_height;
    logic                       base_ground;
    logic signed [17:0]         step;
    logic [17:0]                step_abs;
    logic [RADIUS_W-1:0]        step_mag;
    logic [32:0]                local_prod;
    logic [32:0]                general_prod;
    logic [RADIUS_W-1:0]        local_mag;
    logic [RADIUS_W-1:0]        general_thr;
    logic signed [17:0]         local_raw;
    logic signed [17:0]         local_thr;
    logic signed [19:0]         h_ext;
    logic signed [19:0]         prev_h_ext;
    logic signed [19:0]         gl_ext;
    logic signed [19:0]         t_ext;
    logic signed [19:0]         gen_ext;
    logic                       near_last;
    logic                       near_general;
    logic                       near_ground_local;
    logic                       far_step;
    logic                       is_ground_next;
    out_item_t                  result_next;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_height_reg <= SENSOR_HEIGHT_RST;
            tan_local_reg     <= TAN_LOCAL_RST;
            tan_general_reg   <= TAN_GENERAL_RST;
            min_height_reg    <= MIN_HEIGHT_RST;
            conc_step_reg     <= CONC_STEP_RST;
            reclass_dist_reg  <= RECLASS_DIST_RST;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_SENSOR_HEIGHT: sensor_height_reg <= pwdata[SENSOR_W-1:0];
                REG_TAN_LOCAL:     tan_local_reg     <= pwdata[TAN_W-1:0];
                REG_TAN_GENERAL:   tan_general_reg   <= pwdata[TAN_W-1:0];
                REG_MIN_HEIGHT:    min_height_reg    <= pwdata[MINH_W-1:0];
                REG_CONC_STEP:     conc_step_reg     <= pwdata[CONC_W-1:0];
                REG_RECLASS_DIST:  reclass_dist_reg  <= pwdata[RECL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SENSOR_HEIGHT: prdata = PDATA_W'(sensor_height_reg);
            REG_TAN_LOCAL:     prdata = PDATA_W'(tan_local_reg);
            REG_TAN_GENERAL:   prdata = PDATA_W'(tan_general_reg);
            REG_MIN_HEIGHT:    prdata = PDATA_W'(min_height_reg);
            REG_CONC_STEP:     prdata = PDATA_W'(conc_step_reg);
            REG_RECLASS_DIST:  prdata = PDATA_W'(reclass_dist_reg);
            default:           prdata = '0;
        endcase
    end

    assign advance  = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || advance;
    assign classify = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (classify) begin
            out_data_reg <= result_next;
        end
    end

    always_comb begin
        ground_level = -$signed({1'b0, sensor_height_reg});

        base_radius = in_data_reg.ray_start ? '0 : last_radius_reg;
        base_height = in_data_reg.ray_start ? HEIGHT_W'(ground_level) : last_height_reg;
        base_ground = in_data_reg.ray_start ? 1'b0 : last_ground_reg;

        step     = $signed({1'b0, in_data_reg.radius_mm}) - $signed({1'b0, base_radius});
        step_abs = step[17] ? 18'(-step) : 18'(step);
        step_mag = step_abs[RADIUS_W-1:0];

        local_prod   = 33'(tan_local_reg) * 33'(step_mag);
        general_prod = 33'(tan_general_reg) * 33'(in_data_reg.radius_mm);
        local_mag    = local_prod[32:16];
        general_thr  = general_prod[32:16];

        local_raw = step[17] ? -$signed({1'b0, local_mag}) : $signed({1'b0, local_mag});
        if (step > $signed({6'b0, conc_step_reg})
                && local_raw < $signed({6'b0, min_height_reg})) begin
            local_thr = $signed({6'b0, min_height_reg});
        end else begin
            local_thr = local_raw;
        end

        h_ext      = 20'(in_data_reg.height_mm);
        prev_h_ext = 20'(base_height);
        gl_ext     = 20'(ground_level);
        t_ext      = 20'(local_thr);
        gen_ext    = $signed({3'b0, general_thr});

        near_last         = (h_ext <= prev_h_ext + t_ext) && (h_ext >= prev_h_ext - t_ext);
        near_general      = (h_ext <= gl_ext + gen_ext) && (h_ext >= gl_ext - gen_ext);
        near_ground_local = (h_ext <= gl_ext + t_ext) && (h_ext >= gl_ext - t_ext);
        far_step          = step > $signed({2'b0, reclass_dist_reg});

        is_ground_next = near_last ? (base_ground || near_general)
                                   : (far_step && near_ground_local);

        result_next.is_ground    = is_ground_next;
        result_next.result_index = in_data_reg.point_index;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_radius_reg <= '0;
            last_height_reg <= -$signed({3'b0, SENSOR_HEIGHT_RST});
            last_ground_reg <= 1'b0;
        end else if (classify) begin
            last_radius_reg <= in_data_reg.radius_mm;
            last_height_reg <= in_data_reg.height_mm;
            last_ground_reg <= is_ground_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
